[hw/rtl/c8alu_pkg.sv]
// Shared types and constants of the 8-bit execute unit.
// Used by the channel interfaces, the input stage, the ALU and the top level.
package c8alu_pkg;

  localparam int CMD_W  = 6;
  localparam int BYTE_W = 8;
  localparam int FLAG_W = 7;

  localparam logic [BYTE_W-1:0] SP_RESET = 8'hFF;

  // Bit positions in the internal 7-bit flag word: N V B D I Z C
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_B = 4;
  localparam int FL_V = 5;
  localparam int FL_N = 6;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [FLAG_W-1:0] flags_t;

  typedef enum logic [CMD_W-1:0] {
    OP_ADC   = 6'd0,  OP_AND   = 6'd1,  OP_ASL   = 6'd2,  OP_ASL_A = 6'd3,
    OP_BCC   = 6'd4,  OP_BCS   = 6'd5,  OP_BEQ   = 6'd6,  OP_BIT   = 6'd7,
    OP_BMI   = 6'd8,  OP_BNE   = 6'd9,  OP_BPL   = 6'd10, OP_BVC   = 6'd11,
    OP_BVS   = 6'd12, OP_CLC   = 6'd13, OP_CLD   = 6'd14, OP_CLI   = 6'd15,
    OP_CLV   = 6'd16, OP_CMP   = 6'd17, OP_CPX   = 6'd18, OP_CPY   = 6'd19,
    OP_DEC   = 6'd20, OP_DEX   = 6'd21, OP_DEY   = 6'd22, OP_EOR   = 6'd23,
    OP_INC   = 6'd24, OP_INX   = 6'd25, OP_INY   = 6'd26, OP_LDA   = 6'd27,
    OP_LDX   = 6'd28, OP_LDY   = 6'd29, OP_LSR   = 6'd30, OP_LSR_A = 6'd31,
    OP_NOP   = 6'd32, OP_ORA   = 6'd33, OP_PHA   = 6'd34, OP_PHP   = 6'd35,
    OP_PLA   = 6'd36, OP_PLP   = 6'd37, OP_ROL   = 6'd38, OP_ROL_A = 6'd39,
    OP_ROR   = 6'd40, OP_ROR_A = 6'd41, OP_SBC   = 6'd42, OP_SEC   = 6'd43,
    OP_SED   = 6'd44, OP_SEI   = 6'd45, OP_STA   = 6'd46, OP_STX   = 6'd47,
    OP_STY   = 6'd48, OP_TAX   = 6'd49, OP_TAY   = 6'd50, OP_TSX   = 6'd51,
    OP_TXA   = 6'd52, OP_TXS   = 6'd53, OP_TYA   = 6'd54
  } op_t;

  typedef enum logic [1:0] {
    SOP_NONE = 2'd0,
    SOP_PUSH = 2'd1,
    SOP_POP  = 2'd2
  } sop_t;

  // One accepted input item
  typedef struct packed {
    logic [CMD_W-1:0] command;
    byte_t            operand_value;
  } item_t;

  // Programmer-visible registers
  typedef struct packed {
    byte_t  acc;
    byte_t  x;
    byte_t  y;
    byte_t  sp;
    flags_t flags;
  } arch_t;

  // One result item
  typedef struct packed {
    byte_t write_data;
    logic  mem_write;
    sop_t  stack_op;
    byte_t stack_address_low;
    byte_t status_out;
    logic  branch_taken;
    byte_t accumulator_out;
    byte_t index_x_out;
    byte_t index_y_out;
    byte_t stack_pointer_out;
  } res_t;

  // Flags as seen on the bus: N V 1 B D I Z C
  function automatic byte_t pack_status(input flags_t f);
    return {f[FL_N], f[FL_V], 1'b1, f[FL_B], f[FL_D], f[FL_I], f[FL_Z], f[FL_C]};
  endfunction

endpackage

[hw/rtl/c8alu_if.sv]
// Valid/ready channel interfaces of the 8-bit execute unit.
// Depends on c8alu_pkg.
interface c8alu_in_if;
  import c8alu_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  byte_t            operand_value;

  modport source (output valid, command, operand_value, input ready);
  modport sink   (input valid, command, operand_value, output ready);
endinterface

interface c8alu_out_if;
  import c8alu_pkg::*;
  logic  valid;
  logic  ready;
  byte_t write_data;
  logic  mem_write;
  logic [1:0] stack_op;
  byte_t stack_address_low;
  byte_t status_out;
  logic  branch_taken;
  byte_t accumulator_out;
  byte_t index_x_out;
  byte_t index_y_out;
  byte_t stack_pointer_out;

  modport source (output valid, write_data, mem_write, stack_op, stack_address_low,
                  status_out, branch_taken, accumulator_out, index_x_out,
                  index_y_out, stack_pointer_out, input ready);
  modport sink   (input valid, write_data, mem_write, stack_op, stack_address_low,
                  status_out, branch_taken, accumulator_out, index_x_out,
                  index_y_out, stack_pointer_out, output ready);
endinterface

[hw/rtl/cpu8_register_alu_execute.sv]
// Top level of the 8-bit accumulator execute unit.
// Depends on c8alu_pkg, c8alu_if, c8alu_in_stage and c8alu_exec.
//
// Takes one command and its operand byte per item and returns one result
// item per command: write-back byte, memory write strobe, stack access,
// packed flags (N V 1 B D I Z C), branch condition and the A, X, Y and SP
// registers after the command. An accepted item passes through the input
// register, one pass through the ALU and the result register before its
// result is offered; one item is accepted every cycle as long as the
// result channel keeps up. A, X, Y, SP and the flags are updated in the
// same edge that loads the result register, so a dependent command may
// follow directly. Reset clears A, X, Y and the flags and sets SP to 0xFF.
module cpu8_register_alu_execute (
  input  logic        clk,
  input  logic        rst_n,
  c8alu_in_if.sink    in_chan,
  c8alu_out_if.source out_chan
);
  import c8alu_pkg::*;

  item_t item;
  logic  item_valid;
  logic  exec_fire;

  arch_t arch_r, arch_nxt;
  arch_t exec_arch;
  res_t  exec_res;

  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;

  // input register
  c8alu_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (exec_fire)
  );

  // single-pass ALU on the held item
  c8alu_exec u_exec (
    .item (item),
    .st   (arch_r),
    .nxt  (exec_arch),
    .res  (exec_res)
  );

  // execute when the result register is free or being emptied this cycle
  assign exec_fire = item_valid && (!out_valid_r || out_chan.ready);

  always_comb begin
    arch_nxt = arch_r;
    if (exec_fire) begin
      arch_nxt = exec_arch;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r.acc   <= '0;
      arch_r.x     <= '0;
      arch_r.y     <= '0;
      arch_r.sp    <= SP_RESET;
      arch_r.flags <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      arch_r      <= arch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_res_r <= exec_res;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.write_data        = out_res_r.write_data;
  assign out_chan.mem_write         = out_res_r.mem_write;
  assign out_chan.stack_op          = out_res_r.stack_op;
  assign out_chan.stack_address_low = out_res_r.stack_address_low;
  assign out_chan.status_out        = out_res_r.status_out;
  assign out_chan.branch_taken      = out_res_r.branch_taken;
  assign out_chan.accumulator_out   = out_res_r.accumulator_out;
  assign out_chan.index_x_out       = out_res_r.index_x_out;
  assign out_chan.index_y_out       = out_res_r.index_y_out;
  assign out_chan.stack_pointer_out = out_res_r.stack_pointer_out;

endmodule

[hw/rtl/c8alu_in_stage.sv]
// Input register of the execute unit: captures one item from the input channel.
// Depends on c8alu_pkg and c8alu_in_if.
module c8alu_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  c8alu_in_if.sink          in_chan,
  output c8alu_pkg::item_t  item,
  output logic              item_valid,
  input  logic              item_take
);
  import c8alu_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_chan.ready = !valid_r || item_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_chan.ready) begin
      valid_nxt = in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.command       <= in_chan.command;
      item_r.operand_value <= in_chan.operand_value;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

[hw/rtl/c8alu_exec.sv]
// Combinational ALU: one command against the current register file.
// Depends on c8alu_pkg.
module c8alu_exec (
  input  c8alu_pkg::item_t item,
  input  c8alu_pkg::arch_t st,
  output c8alu_pkg::arch_t nxt,
  output c8alu_pkg::res_t  res
);
  import c8alu_pkg::*;

  // returns {carry out, result}; kind 0 ASL, 1 LSR, 2 ROL, 3 ROR
  function automatic logic [8:0] shift_op(input logic [1:0] kind, input byte_t v,
                                          input logic c);
    logic [8:0] r;
    case (kind)
      2'd0:    r = {v[7], v[6:0], 1'b0};
      2'd1:    r = {v[0], 1'b0, v[7:1]};
      2'd2:    r = {v[7], v[6:0], c};
      default: r = {v[0], c, v[7:1]};
    endcase
    return r;
  endfunction

  op_t        op;
  byte_t      a, m;
  logic       c;
  // binary add/subtract
  logic [8:0] adc_bin, sbc_bin;
  // decimal add
  logic [4:0] dadc_lo_raw, dadc_lo6, dadc_lo;
  logic [8:0] dadc_s;
  logic [9:0] dadc_sa;
  // decimal subtract
  logic [9:0] dsbc_lo, dsbc_lo6, dsbc_loa, dsbc_s, dsbc_sa;
  // compare
  byte_t      cmp_reg;
  logic [8:0] cmp_diff;
  // shifts
  logic [1:0] sh_kind;
  byte_t      sh_src;
  logic [8:0] sh_res;
  byte_t      incdec;
  byte_t      nz_val;
  logic       nz_en;

  assign op = op_t'(item.command);
  assign a  = st.acc;
  assign m  = item.operand_value;
  assign c  = st.flags[FL_C];

  assign adc_bin = {1'b0, a} + {1'b0, m} + {8'd0, c};
  assign sbc_bin = {1'b0, a} + {1'b0, ~m} + {8'd0, c};

  // decimal add, low digit adjust then high digit adjust
  assign dadc_lo_raw = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, c};
  assign dadc_lo6    = dadc_lo_raw + 5'd6;
  assign dadc_lo     = (dadc_lo_raw >= 5'd10) ? {1'b1, dadc_lo6[3:0]} : dadc_lo_raw;
  assign dadc_s      = {1'b0, a[7:4], 4'd0} + {1'b0, m[7:4], 4'd0} + {4'd0, dadc_lo};
  assign dadc_sa     = (dadc_s >= 9'h0A0) ? ({1'b0, dadc_s} + 10'h060) : {1'b0, dadc_s};

  // decimal subtract, signed intermediate in 10 bits
  assign dsbc_lo  = {6'd0, a[3:0]} - {6'd0, m[3:0]} + {9'd0, c} - 10'd1;
  assign dsbc_lo6 = dsbc_lo - 10'd6;
  assign dsbc_loa = dsbc_lo[9] ? ({6'd0, dsbc_lo6[3:0]} - 10'h010) : dsbc_lo;
  assign dsbc_s   = {2'd0, a[7:4], 4'd0} - {2'd0, m[7:4], 4'd0} + dsbc_loa;
  assign dsbc_sa  = dsbc_s[9] ? (dsbc_s - 10'h060) : dsbc_s;

  always_comb begin
    case (op)
      OP_CPX:  cmp_reg = st.x;
      OP_CPY:  cmp_reg = st.y;
      default: cmp_reg = a;
    endcase
  end
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, m};

  always_comb begin
    case (op)
      OP_LSR, OP_LSR_A: sh_kind = 2'd1;
      OP_ROL, OP_ROL_A: sh_kind = 2'd2;
      OP_ROR, OP_ROR_A: sh_kind = 2'd3;
      default:          sh_kind = 2'd0;
    endcase
  end
  assign sh_src = (op == OP_ASL_A || op == OP_LSR_A || op == OP_ROL_A || op == OP_ROR_A)
                  ? a : m;
  assign sh_res = shift_op(sh_kind, sh_src, c);
  assign incdec = (op == OP_INC) ? (m + 8'd1) : (m - 8'd1);

  always_comb begin
    nxt    = st;
    res    = '0;
    nz_en  = 1'b0;
    nz_val = '0;

    case (op)
      OP_ADC: begin
        if (st.flags[FL_D]) begin
          nxt.flags[FL_Z] = (adc_bin[7:0] == 8'd0);
          nxt.flags[FL_N] = dadc_s[7];
          nxt.flags[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ dadc_s[7]);
          nxt.flags[FL_C] = (dadc_sa[9:8] != 2'd0);
          nxt.acc         = dadc_sa[7:0];
        end else begin
          nxt.flags[FL_C] = adc_bin[8];
          nxt.flags[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ adc_bin[7]);
          nxt.acc         = adc_bin[7:0];
          nz_en  = 1'b1;
          nz_val = adc_bin[7:0];
        end
      end
      OP_SBC: begin
        nxt.flags[FL_C] = sbc_bin[8];
        nxt.flags[FL_V] = (a[7] ^ m[7]) & (a[7] ^ sbc_bin[7]);
        nz_en  = 1'b1;
        nz_val = sbc_bin[7:0];
        nxt.acc = st.flags[FL_D] ? dsbc_sa[7:0] : sbc_bin[7:0];
      end
      OP_AND: begin nxt.acc = a & m; nz_en = 1'b1; nz_val = a & m; end
      OP_EOR: begin nxt.acc = a ^ m; nz_en = 1'b1; nz_val = a ^ m; end
      OP_ORA: begin nxt.acc = a | m; nz_en = 1'b1; nz_val = a | m; end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        nxt.flags[FL_C] = sh_res[8];
        nz_en  = 1'b1;
        nz_val = sh_res[7:0];
        res.write_data = sh_res[7:0];
        res.mem_write  = 1'b1;
      end
      OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
        nxt.flags[FL_C] = sh_res[8];
        nz_en  = 1'b1;
        nz_val = sh_res[7:0];
        nxt.acc = sh_res[7:0];
      end
      OP_BCC: res.branch_taken = ~st.flags[FL_C];
      OP_BCS: res.branch_taken =  st.flags[FL_C];
      OP_BEQ: res.branch_taken =  st.flags[FL_Z];
      OP_BNE: res.branch_taken = ~st.flags[FL_Z];
      OP_BMI: res.branch_taken =  st.flags[FL_N];
      OP_BPL: res.branch_taken = ~st.flags[FL_N];
      OP_BVS: res.branch_taken =  st.flags[FL_V];
      OP_BVC: res.branch_taken = ~st.flags[FL_V];
      OP_BIT: begin
        nxt.flags[FL_N] = m[7];
        nxt.flags[FL_V] = m[6];
        nxt.flags[FL_Z] = ((a & m) == 8'd0);
      end
      OP_CLC: nxt.flags[FL_C] = 1'b0;
      OP_CLD: nxt.flags[FL_D] = 1'b0;
      OP_CLI: nxt.flags[FL_I] = 1'b0;
      OP_CLV: nxt.flags[FL_V] = 1'b0;
      OP_SEC: nxt.flags[FL_C] = 1'b1;
      OP_SED: nxt.flags[FL_D] = 1'b1;
      OP_SEI: nxt.flags[FL_I] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        nxt.flags[FL_C] = ~cmp_diff[8];
        nz_en  = 1'b1;
        nz_val = cmp_diff[7:0];
      end
      OP_DEC, OP_INC: begin
        nz_en  = 1'b1;
        nz_val = incdec;
        res.write_data = incdec;
        res.mem_write  = 1'b1;
      end
      OP_DEX: begin nxt.x = st.x - 8'd1; nz_en = 1'b1; nz_val = st.x - 8'd1; end
      OP_DEY: begin nxt.y = st.y - 8'd1; nz_en = 1'b1; nz_val = st.y - 8'd1; end
      OP_INX: begin nxt.x = st.x + 8'd1; nz_en = 1'b1; nz_val = st.x + 8'd1; end
      OP_INY: begin nxt.y = st.y + 8'd1; nz_en = 1'b1; nz_val = st.y + 8'd1; end
      OP_LDA: begin nxt.acc = m; nz_en = 1'b1; nz_val = m; end
      OP_LDX: begin nxt.x   = m; nz_en = 1'b1; nz_val = m; end
      OP_LDY: begin nxt.y   = m; nz_en = 1'b1; nz_val = m; end
      OP_PHA, OP_PHP: begin
        // push: write at the old pointer, then decrement
        res.write_data        = (op == OP_PHA) ? a : (pack_status(st.flags) | 8'h30);
        res.stack_op          = SOP_PUSH;
        res.stack_address_low = st.sp;
        nxt.sp                = st.sp - 8'd1;
      end
      OP_PLA: begin
        // pull: increment, then read at the new pointer
        nxt.sp                = st.sp + 8'd1;
        res.stack_op          = SOP_POP;
        res.stack_address_low = st.sp + 8'd1;
        nxt.acc = m;
        nz_en   = 1'b1;
        nz_val  = m;
      end
      OP_PLP: begin
        nxt.sp                = st.sp + 8'd1;
        res.stack_op          = SOP_POP;
        res.stack_address_low = st.sp + 8'd1;
        nxt.flags             = {m[7], m[6], m[4:0]};
      end
      OP_STA: begin res.write_data = a;    res.mem_write = 1'b1; end
      OP_STX: begin res.write_data = st.x; res.mem_write = 1'b1; end
      OP_STY: begin res.write_data = st.y; res.mem_write = 1'b1; end
      OP_TAX: begin nxt.x   = a;     nz_en = 1'b1; nz_val = a;     end
      OP_TAY: begin nxt.y   = a;     nz_en = 1'b1; nz_val = a;     end
      OP_TSX: begin nxt.x   = st.sp; nz_en = 1'b1; nz_val = st.sp; end
      OP_TXA: begin nxt.acc = st.x;  nz_en = 1'b1; nz_val = st.x;  end
      OP_TYA: begin nxt.acc = st.y;  nz_en = 1'b1; nz_val = st.y;  end
      OP_TXS: nxt.sp = st.x;
      default: ;  // NOP and unused codes
    endcase

    if (nz_en) begin
      nxt.flags[FL_N] = nz_val[7];
      nxt.flags[FL_Z] = (nz_val == 8'd0);
    end

    res.status_out        = pack_status(nxt.flags);
    res.accumulator_out   = nxt.acc;
    res.index_x_out       = nxt.x;
    res.index_y_out       = nxt.y;
    res.stack_pointer_out = nxt.sp;
  end

endmodule

[sim/cpu8_register_alu_execute_tb.sv]
// Self-checking testbench for the 8-bit accumulator execute unit.
// Depends on c8alu_pkg, c8alu_if and the cpu8_register_alu_execute RTL.
// A directed table runs first, then random command streams checked by the predictor.
module cpu8_register_alu_execute_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import c8alu_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 4;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int IDLE_PERCENT   = 32;
  localparam int DRAIN_CYCLES   = 8;          // margin after the last result is taken
  localparam int TIMEOUT_NS     = 3_000_000;  // far above a slow clean run
  // Stretches where one side never idles, and the long receiver hold-off
  localparam int SEND_STEADY_LO = 600;
  localparam int SEND_STEADY_HI = 900;
  localparam int TAKE_STEADY_LO = 1200;
  localparam int TAKE_STEADY_HI = 1500;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 64;

  // Command numbers past the last real operation; the block runs them as a no-op
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 6'd55;
  localparam logic [CMD_W-1:0] CMD_UNUSED_TOP   = 6'd63;

  typedef enum int {SH_ASL, SH_LSR, SH_ROL, SH_ROR} shift_kind_t;

  // One row of the directed table. Where fixed is set, want is the result
  // worked out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [CMD_W-1:0] code;
    byte_t            opnd;
    logic             fixed;
    res_t             want;
  } step_t;

  localparam res_t NO_LITERAL = '0;
  localparam int PLAN_LEN = 25;

  // Literal field order: write_data, mem_write, stack_op, stack_address_low,
  // status_out, branch_taken, A, X, Y, SP
  localparam step_t PLAN [PLAN_LEN] = '{
    // state straight out of reset
    {OP_NOP, 8'h00, 1'b1,
     {8'h00, 1'b0, SOP_NONE, 8'h00, 8'h20, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF}},
    // PHP forces bits 5 and 4 in the pushed byte
    {OP_PHP, 8'hFF, 1'b1,
     {8'h30, 1'b0, SOP_PUSH, 8'hFF, 8'h20, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFE}},
    // PLP of all ones sets every flag
    {OP_PLP, 8'hFF, 1'b1,
     {8'h00, 1'b0, SOP_POP, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF}},
    // pop wraps SP from FF to 00
    {OP_PLA, 8'h00, 1'b1,
     {8'h00, 1'b0, SOP_POP, 8'h00, 8'h7F, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
    // push wraps SP back; operand ignored
    {OP_PHA, 8'h5A, 1'b1,
     {8'h00, 1'b0, SOP_PUSH, 8'h00, 8'h7F, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF}},
    {OP_PHP, 8'h00, 1'b1,
     {8'h7F, 1'b0, SOP_PUSH, 8'hFF, 8'h7F, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFE}},
    // decimal mode is on here, carry set
    {OP_ADC, 8'h99, 1'b0, NO_LITERAL},
    {OP_SBC, 8'h01, 1'b0, NO_LITERAL},
    {OP_ADC, 8'h0F, 1'b0, NO_LITERAL},   // bad BCD digit
    {OP_SBC, 8'hFF, 1'b0, NO_LITERAL},   // bad BCD digits both halves
    {OP_CLD, 8'h00, 1'b0, NO_LITERAL},
    {OP_CLV, 8'h00, 1'b0, NO_LITERAL},
    {OP_CLC, 8'h00, 1'b0, NO_LITERAL},
    {OP_LDA, 8'h7F, 1'b0, NO_LITERAL},
    {OP_ADC, 8'h01, 1'b0, NO_LITERAL},   // signed overflow
    {OP_SBC, 8'h80, 1'b0, NO_LITERAL},
    {OP_BIT, 8'hC0, 1'b0, NO_LITERAL},
    {OP_BVS, 8'h00, 1'b0, NO_LITERAL},
    {OP_CMP, 8'hFF, 1'b0, NO_LITERAL},
    {OP_ASL, 8'h80, 1'b0, NO_LITERAL},
    {OP_ROR, 8'h01, 1'b0, NO_LITERAL},
    {OP_LDX, 8'hFF, 1'b0, NO_LITERAL},
    {OP_INX, 8'h00, 1'b0, NO_LITERAL},   // X wraps to zero
    {OP_TXS, 8'h00, 1'b0, NO_LITERAL},
    {CMD_UNUSED_TOP, 8'hAA, 1'b0, NO_LITERAL}
  };

  localparam op_t   FLAG_OPS [4]     = '{OP_SED, OP_CLD, OP_SEC, OP_CLC};
  localparam byte_t CORNER_BYTES [8] =
    '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'h0F, 8'h99, 8'hF0};

  logic clk = 1'b0;
  logic rst_n;

  c8alu_in_if  in_bus ();
  c8alu_out_if out_bus ();

  cpu8_register_alu_execute dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor's copy of the programmer-visible registers
  byte_t  reg_a  = 8'h00;
  byte_t  reg_x  = 8'h00;
  byte_t  reg_y  = 8'h00;
  byte_t  reg_sp = SP_RESET;
  flags_t reg_p  = '0;

  res_t expected_q [$];
  int   mismatches = 0;
  int   sent       = 0;
  int   taken      = 0;
  logic holding    = 1'b0;   // receiver hold-off in progress, seen by the sender

  function automatic void set_nz(input byte_t v);
    reg_p[FL_N] = v[7];
    reg_p[FL_Z] = (v == 8'h00);
  endfunction

  // Flags as they appear on the bus: N V 1 B D I Z C
  function automatic byte_t status_byte();
    return {reg_p[FL_N], reg_p[FL_V], 1'b1, reg_p[FL_B:FL_C]};
  endfunction

  function automatic byte_t shift_op(input shift_kind_t kind, input byte_t v);
    byte_t r;
    logic  c;
    c = reg_p[FL_C];
    case (kind)
      SH_ASL:  r = {v[6:0], 1'b0};
      SH_LSR:  r = {1'b0, v[7:1]};
      SH_ROL:  r = {v[6:0], c};
      default: r = {c, v[7:1]};
    endcase
    reg_p[FL_C] = (kind == SH_ASL || kind == SH_ROL) ? v[7] : v[0];
    set_nz(r);
    return r;
  endfunction

  function automatic void compare_with(input byte_t r, input byte_t m);
    reg_p[FL_C] = (r >= m);
    set_nz(r - m);
  endfunction

  // Executes one command on the predictor's registers and returns the result item
  function automatic res_t run_command(input logic [CMD_W-1:0] code, input byte_t m);
    res_t  r;
    byte_t a, b;
    logic  c;
    int    bin, lo, s;
    r = '0;
    r.stack_op = SOP_NONE;
    a = reg_a;
    c = reg_p[FL_C];   // carry in is taken before any flag moves
    case (op_t'(code))
      OP_ADC: begin
        bin = a + m + c;
        if (reg_p[FL_D]) begin
          // NMOS decimal add: Z from binary sum, N/V before the high-digit fix
          lo = (a & 8'h0F) + (m & 8'h0F) + c;
          if (lo >= 10)
            lo = ((lo + 6) & 15) + 16;
          s = (a & 8'hF0) + (m & 8'hF0) + lo;
          reg_p[FL_Z] = (bin[7:0] == 8'h00);
          reg_p[FL_N] = s[7];
          reg_p[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ s[7]);
          if (s >= 'hA0)
            s = s + 'h60;
          reg_p[FL_C] = (s >= 'h100);
          reg_a = s[7:0];
        end else begin
          reg_p[FL_C] = (bin > 255);
          reg_p[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ bin[7]);
          set_nz(bin[7:0]);
          reg_a = bin[7:0];
        end
      end
      OP_SBC: begin
        // flags always come from the binary difference
        b = ~m;
        bin = a + b + c;
        reg_p[FL_C] = (bin > 255);
        reg_p[FL_V] = ~(a[7] ^ b[7]) & (a[7] ^ bin[7]);
        set_nz(bin[7:0]);
        if (reg_p[FL_D]) begin
          lo = (a & 8'h0F) - (m & 8'h0F) + c - 1;
          if (lo < 0)
            lo = ((lo - 6) & 15) - 16;
          s = (a & 8'hF0) - (m & 8'hF0) + lo;
          if (s < 0)
            s = s - 'h60;
          reg_a = s[7:0];
        end else begin
          reg_a = bin[7:0];
        end
      end
      OP_AND: begin reg_a = a & m; set_nz(reg_a); end
      OP_EOR: begin reg_a = a ^ m; set_nz(reg_a); end
      OP_ORA: begin reg_a = a | m; set_nz(reg_a); end
      OP_ASL: begin r.write_data = shift_op(SH_ASL, m); r.mem_write = 1'b1; end
      OP_LSR: begin r.write_data = shift_op(SH_LSR, m); r.mem_write = 1'b1; end
      OP_ROL: begin r.write_data = shift_op(SH_ROL, m); r.mem_write = 1'b1; end
      OP_ROR: begin r.write_data = shift_op(SH_ROR, m); r.mem_write = 1'b1; end
      OP_ASL_A: reg_a = shift_op(SH_ASL, a);
      OP_LSR_A: reg_a = shift_op(SH_LSR, a);
      OP_ROL_A: reg_a = shift_op(SH_ROL, a);
      OP_ROR_A: reg_a = shift_op(SH_ROR, a);
      OP_BCC: r.branch_taken = ~reg_p[FL_C];
      OP_BCS: r.branch_taken = reg_p[FL_C];
      OP_BEQ: r.branch_taken = reg_p[FL_Z];
      OP_BNE: r.branch_taken = ~reg_p[FL_Z];
      OP_BMI: r.branch_taken = reg_p[FL_N];
      OP_BPL: r.branch_taken = ~reg_p[FL_N];
      OP_BVS: r.branch_taken = reg_p[FL_V];
      OP_BVC: r.branch_taken = ~reg_p[FL_V];
      OP_BIT: begin
        reg_p[FL_N] = m[7];
        reg_p[FL_V] = m[6];
        reg_p[FL_Z] = ((a & m) == 8'h00);
      end
      OP_CLC: reg_p[FL_C] = 1'b0;
      OP_CLD: reg_p[FL_D] = 1'b0;
      OP_CLI: reg_p[FL_I] = 1'b0;
      OP_CLV: reg_p[FL_V] = 1'b0;
      OP_SEC: reg_p[FL_C] = 1'b1;
      OP_SED: reg_p[FL_D] = 1'b1;
      OP_SEI: reg_p[FL_I] = 1'b1;
      OP_CMP: compare_with(a, m);
      OP_CPX: compare_with(reg_x, m);
      OP_CPY: compare_with(reg_y, m);
      OP_DEC: begin r.write_data = m - 8'd1; set_nz(r.write_data); r.mem_write = 1'b1; end
      OP_INC: begin r.write_data = m + 8'd1; set_nz(r.write_data); r.mem_write = 1'b1; end
      OP_DEX: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
      OP_DEY: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
      OP_INX: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
      OP_INY: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
      OP_LDA: begin reg_a = m; set_nz(m); end
      OP_LDX: begin reg_x = m; set_nz(m); end
      OP_LDY: begin reg_y = m; set_nz(m); end
      OP_PHA, OP_PHP: begin
        // push addresses the slot at SP, then SP moves down
        r.write_data = (op_t'(code) == OP_PHA) ? a : (status_byte() | 8'h30);
        r.stack_op = SOP_PUSH;
        r.stack_address_low = reg_sp;
        reg_sp = reg_sp - 8'd1;
      end
      OP_PLA, OP_PLP: begin
        // pop moves SP up first, then reads there
        reg_sp = reg_sp + 8'd1;
        r.stack_op = SOP_POP;
        r.stack_address_low = reg_sp;
        if (op_t'(code) == OP_PLA) begin
          reg_a = m;
          set_nz(m);
        end else begin
          reg_p = {m[7:6], m[4:0]};   // bit 5 of the popped byte is dropped
        end
      end
      OP_STA: begin r.write_data = a;     r.mem_write = 1'b1; end
      OP_STX: begin r.write_data = reg_x; r.mem_write = 1'b1; end
      OP_STY: begin r.write_data = reg_y; r.mem_write = 1'b1; end
      OP_TAX: begin reg_x = a;      set_nz(reg_x); end
      OP_TAY: begin reg_y = a;      set_nz(reg_y); end
      OP_TSX: begin reg_x = reg_sp; set_nz(reg_x); end
      OP_TXA: begin reg_a = reg_x;  set_nz(reg_a); end
      OP_TYA: begin reg_a = reg_y;  set_nz(reg_a); end
      OP_TXS: reg_sp = reg_x;       // no flag change
      default: ;                    // NOP and the unused numbers
    endcase
    r.status_out        = status_byte();
    r.accumulator_out   = reg_a;
    r.index_x_out       = reg_x;
    r.index_y_out       = reg_y;
    r.stack_pointer_out = reg_sp;
    return r;
  endfunction

  // Offers one item, waits for it to be taken, then queues its expected result.
  // The sender stays busy during the receiver hold-off so the pipe backs up.
  task automatic offer(input logic [CMD_W-1:0] code, input byte_t opnd,
                       input logic fixed, input res_t want);
    res_t predicted;
    while (!holding && !(sent >= SEND_STEADY_LO && sent < SEND_STEADY_HI) &&
           $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.command       <= code;
    in_bus.operand_value <= opnd;
    @(posedge clk);
    while (!in_bus.ready)
      @(posedge clk);
    predicted = run_command(code, opnd);
    expected_q.push_back(fixed ? want : predicted);
    sent++;
  endtask

  function automatic void note_field(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %02h got %02h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic take_result();
    res_t want;
    res_t got;
    got.write_data        = out_bus.write_data;
    got.mem_write         = out_bus.mem_write;
    got.stack_op          = sop_t'(out_bus.stack_op);
    got.stack_address_low = out_bus.stack_address_low;
    got.status_out        = out_bus.status_out;
    got.branch_taken      = out_bus.branch_taken;
    got.accumulator_out   = out_bus.accumulator_out;
    got.index_x_out       = out_bus.index_x_out;
    got.index_y_out       = out_bus.index_y_out;
    got.stack_pointer_out = out_bus.stack_pointer_out;
    taken++;
    if (expected_q.size() == 0) begin
      $display("%0t: result item with none expected, got %h", $time, got);
      mismatches++;
    end else begin
      want = expected_q.pop_front();
      note_field("write_data",        want.write_data,        got.write_data);
      note_field("mem_write",         want.mem_write,         got.mem_write);
      note_field("stack_op",          want.stack_op,          got.stack_op);
      note_field("stack_address_low", want.stack_address_low, got.stack_address_low);
      note_field("status_out",        want.status_out,        got.status_out);
      note_field("branch_taken",      want.branch_taken,      got.branch_taken);
      note_field("accumulator_out",   want.accumulator_out,   got.accumulator_out);
      note_field("index_x_out",       want.index_x_out,       got.index_x_out);
      note_field("index_y_out",       want.index_y_out,       got.index_y_out);
      note_field("stack_pointer_out", want.stack_pointer_out, got.stack_pointer_out);
    end
  endtask

  // Receiver: checks each taken item, then picks ready for the next edge.
  // One long hold-off after HOLD_AT items; a steady window with ready held high.
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        take_result();
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
        holding <= (hold_left > 0);
      end else if (taken >= HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_bus.ready <= 1'b0;
        holding <= 1'b1;
      end else if (taken >= TAKE_STEADY_LO && taken < TAKE_STEADY_HI) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Stimulus: reset, directed table, random stream, drain, verdict
  initial begin
    int          pick;
    logic [CMD_W-1:0] code;
    byte_t       opnd;
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.command       <= OP_NOP;
    in_bus.operand_value <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++)
      offer(PLAN[i].code, PLAN[i].opnd, PLAN[i].fixed, PLAN[i].want);

    // Mostly real operations; a share of mode flips keeps decimal mode and
    // carry moving, and a few unused numbers test the no-op path
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        code = CMD_W'($urandom_range(int'(CMD_FIRST_UNUSED), int'(CMD_UNUSED_TOP)));
      else if (pick < 12)
        code = FLAG_OPS[$urandom_range(0, 3)];
      else
        code = CMD_W'($urandom_range(0, int'(OP_TYA)));
      if ($urandom_range(0, 3) == 0)
        opnd = CORNER_BYTES[$urandom_range(0, 7)];
      else
        opnd = 8'($urandom_range(0, 255));
      offer(code, opnd, 1'b0, NO_LITERAL);
    end
    in_bus.valid <= 1'b0;

    while (expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("cpu8_register_alu_execute verification clean");
    else
      $display("cpu8_register_alu_execute verification failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timed out with %0d results outstanding", $time, expected_q.size());
    $display("cpu8_register_alu_execute verification failed");
    $finish;
  end

endmodule
